@@ sv/cpc_pkg.sv @@
// Package for the paint colour parser: keyword table, byte helpers and shared types.
// Used by cpc_kw_match and css_paint_colour_parser_top; depends on nothing.
`default_nettype none

package cpc_pkg;

  localparam int unsigned KEYWORD_COUNT_DEFAULT = 12;
  localparam int unsigned TABLE_SIZE = 12;
  localparam int unsigned KW_CHARS = 6;

  localparam logic [3:0] LEN_MAX = 4'd15;
  localparam logic [7:0] HASH_BYTE = 8'h23;
  localparam logic [3:0] HEX_SHORT_DIGITS = 4'd3;
  localparam logic [3:0] HEX_LONG_DIGITS = 4'd6;

  localparam logic [7:0] KW_TEXT [TABLE_SIZE][KW_CHARS] = '{
    '{8'h62, 8'h6c, 8'h61, 8'h63, 8'h6b, 8'h00},  // black
    '{8'h77, 8'h68, 8'h69, 8'h74, 8'h65, 8'h00},  // white
    '{8'h72, 8'h65, 8'h64, 8'h00, 8'h00, 8'h00},  // red
    '{8'h67, 8'h72, 8'h65, 8'h65, 8'h6e, 8'h00},  // green
    '{8'h62, 8'h6c, 8'h75, 8'h65, 8'h00, 8'h00},  // blue
    '{8'h67, 8'h72, 8'h61, 8'h79, 8'h00, 8'h00},  // gray
    '{8'h67, 8'h72, 8'h65, 8'h79, 8'h00, 8'h00},  // grey
    '{8'h73, 8'h69, 8'h6c, 8'h76, 8'h65, 8'h72},  // silver
    '{8'h6d, 8'h61, 8'h72, 8'h6f, 8'h6f, 8'h6e},  // maroon
    '{8'h6e, 8'h61, 8'h76, 8'h79, 8'h00, 8'h00},  // navy
    '{8'h79, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h77},  // yellow
    '{8'h6f, 8'h72, 8'h61, 8'h6e, 8'h67, 8'h65}   // orange
  };

  localparam logic [3:0] KW_LEN [TABLE_SIZE] = '{
    4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4, 4'd6, 4'd6
  };

  localparam logic [23:0] KW_RGB [TABLE_SIZE] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h008000, 24'h0000FF, 24'h808080,
    24'h808080, 24'hC0C0C0, 24'h800000, 24'h000080, 24'hFFFF00, 24'hFFA500
  };

  typedef struct packed {
    logic        hit;
    logic [23:0] rgb;
  } kw_result_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] l;
    logic [4:0] v;
    l = fold(b);
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if (l >= 8'h61 && l <= 8'h66) begin
      v = {1'b0, l[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/cpc_kw_match.sv @@
// Keyword matcher: narrows the per-keyword match flags by one byte and picks the colour.
// Depends on cpc_pkg for the keyword table and the result type.
`default_nettype none

module cpc_kw_match #(
  parameter int unsigned KeywordCount = cpc_pkg::KEYWORD_COUNT_DEFAULT
) (
  input  wire logic                    take_i,
  input  wire logic [7:0]              folded_i,
  input  wire logic [3:0]              pos_i,
  input  wire logic [3:0]              len_i,
  input  wire logic [KeywordCount-1:0] flags_i,
  output logic      [KeywordCount-1:0] flags_o,
  output cpc_pkg::kw_result_t          result_o
);

  logic [KeywordCount-1:0] hit;
  logic [23:0]             kw_rgb [KeywordCount];

  for (genvar k = 0; k < KeywordCount; k++) begin : g_kw
    if (k < cpc_pkg::TABLE_SIZE) begin : g_real
      logic fits;
      assign fits = (pos_i < cpc_pkg::KW_LEN[k]) &&
                    (cpc_pkg::KW_TEXT[k][pos_i[2:0]] == folded_i);
      assign flags_o[k] = flags_i[k] & (fits | ~take_i);
      assign hit[k] = flags_o[k] && (len_i == cpc_pkg::KW_LEN[k]);
      assign kw_rgb[k] = cpc_pkg::KW_RGB[k];
    end else begin : g_none
      assign flags_o[k] = flags_i[k] & ~take_i;
      assign hit[k] = 1'b0;
      assign kw_rgb[k] = 24'h000000;
    end
  end

  always_comb begin
    result_o = '0;
    for (int k = KeywordCount - 1; k >= 0; k--) begin
      if (hit[k]) begin
        result_o.hit = 1'b1;
        result_o.rgb = kw_rgb[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/css_paint_colour_parser_top.sv @@
// Top level of the paint colour parser: input register, span state, result register.
// Depends on cpc_pkg and instantiates cpc_kw_match.
//
// Channel   Direction  Carries
// s_axis    in         tdata = text_byte, tuser = byte_present, tlast = span_end
// m_axis    out        tdata = colour_rgb, tuser = no_paint
//
// One byte is taken every cycle while the result register is not stalled; a result leaves
// through the input register and the result register after the transfer that closes its span.
// The span state is updated by one pass of logic between those two registers.
// A stalled result register holds both stages; s_axis_tready falls only then.
// Reset clears both stages and returns the span state to its start values.
`default_nettype none

module css_paint_colour_parser_top #(
  parameter int unsigned KeywordCount = cpc_pkg::KEYWORD_COUNT_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tuser,   // [0] byte_present
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [23:0] colour_rgb
  output logic             m_axis_tuser    // [0] no_paint
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_present_q;
  logic       in_last_q;
  logic       advance;

  logic [3:0]              len_q, len_d;
  logic                    hash_q, hash_d;
  logic [23:0]             acc_q, acc_d;
  logic                    ok_q, ok_d;
  logic [KeywordCount-1:0] flags_q, flags_d;

  logic [4:0]          hex_v;
  logic                take;
  logic [23:0]         rgb_d;
  logic                no_paint_d;
  logic [3:0]          digits;
  cpc_pkg::kw_result_t kw_res;

  assign advance = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | advance;
  assign take = in_valid_q & in_present_q;
  assign hex_v = cpc_pkg::hex_value(in_byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q    <= s_axis_tdata;
      in_present_q <= s_axis_tuser;
      in_last_q    <= s_axis_tlast;
    end
  end

  always_comb begin
    len_d  = len_q;
    hash_d = hash_q;
    acc_d  = acc_q;
    ok_d   = ok_q;
    if (take) begin
      if (len_q == 4'd0) begin
        hash_d = (in_byte_q == cpc_pkg::HASH_BYTE);
      end else if (hex_v[4]) begin
        ok_d = 1'b0;
      end else begin
        acc_d = {acc_q[19:0], hex_v[3:0]};
      end
      if (len_q != cpc_pkg::LEN_MAX) begin
        len_d = len_q + 4'd1;
      end
    end
  end

  cpc_kw_match #(
    .KeywordCount(KeywordCount)
  ) u_kw_match (
    .take_i  (take),
    .folded_i(cpc_pkg::fold(in_byte_q)),
    .pos_i   (len_q),
    .len_i   (len_d),
    .flags_i (flags_q),
    .flags_o (flags_d),
    .result_o(kw_res)
  );

  always_comb begin
    digits     = len_d - 4'd1;
    rgb_d      = 24'h000000;
    no_paint_d = 1'b1;
    if (len_d == 4'd0) begin
      no_paint_d = 1'b1;
    end else if (hash_d) begin
      if (ok_d && digits == cpc_pkg::HEX_LONG_DIGITS) begin
        rgb_d      = acc_d;
        no_paint_d = 1'b0;
      end else if (ok_d && digits == cpc_pkg::HEX_SHORT_DIGITS) begin
        rgb_d      = {acc_d[11:8], acc_d[11:8], acc_d[7:4], acc_d[7:4],
                      acc_d[3:0], acc_d[3:0]};
        no_paint_d = 1'b0;
      end
    end else if (kw_res.hit) begin
      rgb_d      = kw_res.rgb;
      no_paint_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= 4'd0;
      hash_q  <= 1'b0;
      acc_q   <= 24'h000000;
      ok_q    <= 1'b1;
      flags_q <= '1;
    end else if (advance && in_valid_q) begin
      if (in_last_q) begin
        len_q   <= 4'd0;
        hash_q  <= 1'b0;
        acc_q   <= 24'h000000;
        ok_q    <= 1'b1;
        flags_q <= '1;
      end else begin
        len_q   <= len_d;
        hash_q  <= hash_d;
        acc_q   <= acc_d;
        ok_q    <= ok_d;
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid_q & in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && in_last_q) begin
      m_axis_tdata <= rgb_d;
      m_axis_tuser <= no_paint_d;
    end
  end

endmodule

`default_nettype wire

@@ bench/css_paint_colour_parser_top_tb.sv @@
// Self-checking bench for css_paint_colour_parser_top: paint value bytes in, colour out.
// Directed table then random spans; results are compared against table values or an in-bench parser model.
// Depends on the css_paint_colour_parser_top RTL only.
`timescale 1ns / 100ps

module css_paint_colour_parser_top_tb;

  localparam logic [7:0] HASH_CHAR = 8'h23;
  localparam logic [3:0] SPAN_CAP = 4'd15;
  localparam int NAME_COUNT = 12;
  localparam int ITEM_TARGET = 600;
  localparam int SQUEEZE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [23:0] rgb;
    logic        np;
  } paint_t;

  typedef struct {
    string       text;
    bit          close_empty;
    bit          gap_empty;
    bit          typed;
    logic [23:0] rgb;
    logic        np;
  } paint_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic        s_axis_tuser = 1'b0;    // [0] byte_present
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [23:0] colour_rgb
  logic        m_axis_tuser;           // [0] no_paint

  css_paint_colour_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  string paint_name [NAME_COUNT] = '{
    "black", "white", "red", "green", "blue", "gray",
    "grey", "silver", "maroon", "navy", "yellow", "orange"
  };
  logic [23:0] paint_rgb [NAME_COUNT] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h008000, 24'h0000FF, 24'h808080,
    24'h808080, 24'hC0C0C0, 24'h800000, 24'h000080, 24'hFFFF00, 24'hFFA500
  };
  string hex_chars = "0123456789abcdefABCDEF";

  paint_case_t paint_cases [27] = '{
    '{"",                 1'b1, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"#FFF",             1'b0, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{"#000000",          1'b0, 1'b0, 1'b1, 24'h000000, 1'b0},
    '{"#fFfFfF",          1'b0, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{"#1a2",             1'b1, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"#A5c9E0",          1'b0, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{"#12",              1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"#12g456",          1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"#",                1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"#1234567",         1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"none",             1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"NoNe",             1'b1, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"BLACK",            1'b0, 1'b0, 1'b1, 24'h000000, 1'b0},
    '{"white",            1'b0, 1'b1, 1'b1, 24'hFFFFFF, 1'b0},
    '{"red",              1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"Green",            1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"bLue",             1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"gray",             1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"GREY",             1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"silver",           1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"Maroon",           1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"navy",             1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"yellow",           1'b0, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{"orangE",           1'b1, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{"redd",             1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"bluegreenredgray", 1'b0, 1'b0, 1'b1, 24'h000000, 1'b1},
    '{"\377\200",         1'b0, 1'b0, 1'b1, 24'h000000, 1'b1}
  };

  logic [3:0]  span_len;
  logic        hash_first;
  logic [23:0] hex_acc;
  logic        hex_ok;
  logic [11:0] name_alive;

  paint_t      colour_due [$];
  logic [7:0]  span_text [$];
  int          items_sent = 0;
  int          errors = 0;
  int          cycles = 0;
  bit          steady = 1'b0;
  bit          squeeze_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] lower_case(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  // Bit 4 flags a byte that is not a hex digit.
  function automatic logic [4:0] digit_value(input logic [7:0] b);
    logic [7:0] l;
    l = lower_case(b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, b[3:0]};
    if (l >= 8'h61 && l <= 8'h66) return 5'(l - 8'h61 + 8'd10);
    return 5'h10;
  endfunction

  task automatic paint_clear();
    span_len = 4'd0;
    hash_first = 1'b0;
    hex_acc = 24'h0;
    hex_ok = 1'b1;
    name_alive = '1;
  endtask

  task automatic paint_take(input logic [7:0] b);
    logic [7:0] l;
    logic [4:0] v;
    l = lower_case(b);
    if (span_len == 4'd0) begin
      hash_first = (b == HASH_CHAR);
    end else begin
      v = digit_value(b);
      if (v[4]) begin
        hex_ok = 1'b0;
      end else begin
        hex_acc = {hex_acc[19:0], v[3:0]};
      end
    end
    for (int k = 0; k < NAME_COUNT; k++) begin
      if (!(span_len < paint_name[k].len() && paint_name[k][span_len] == l)) begin
        name_alive[k] = 1'b0;
      end
    end
    if (span_len != SPAN_CAP) begin
      span_len = span_len + 4'd1;
    end
  endtask

  function automatic paint_t paint_close();
    paint_t r;
    bit found;
    r.rgb = 24'h0;
    r.np = 1'b1;
    found = 1'b0;
    if (span_len == 4'd0) return r;
    if (hash_first) begin
      if (hex_ok && span_len == 4'd7) begin
        r.rgb = hex_acc;
        r.np = 1'b0;
      end else if (hex_ok && span_len == 4'd4) begin
        r.rgb = {{2{hex_acc[11:8]}}, {2{hex_acc[7:4]}}, {2{hex_acc[3:0]}}};
        r.np = 1'b0;
      end
      return r;
    end
    for (int k = 0; k < NAME_COUNT; k++) begin
      if (!found && name_alive[k] && span_len == paint_name[k].len()) begin
        r.rgb = paint_rgb[k];
        r.np = 1'b0;
        found = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic push_item(input logic [7:0] d, input logic p, input logic l, input bit typed,
                           input paint_t want);
    paint_t got;
    while (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= p;
    s_axis_tlast <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (p) begin
      paint_take(d);
    end
    if (l) begin
      got = paint_close();
      paint_clear();
      if (typed) begin
        colour_due.push_back(want);
      end else begin
        colour_due.push_back(got);
      end
    end
  endtask

  task automatic send_span(input bit close_empty, input bit gap_empty, input bit typed,
                           input paint_t want);
    int n;
    int gap_at;
    bit closer;
    n = span_text.size();
    closer = close_empty || (n == 0);
    gap_at = (n > 0) ? $urandom_range(n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      if (gap_empty && i == gap_at) begin
        push_item(8'($urandom_range(255)), 1'b0, 1'b0, typed, want);
      end
      push_item(span_text[i], 1'b1, (i == n - 1) && !closer, typed, want);
    end
    if (closer) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1, typed, want);
    end
  endtask

  task automatic build_random_span();
    int pick;
    int n;
    string word;
    span_text.delete();
    pick = $urandom_range(99);
    if (pick < 30) begin
      word = paint_name[$urandom_range(NAME_COUNT - 1)];
      for (int i = 0; i < word.len(); i++) span_text.push_back(word[i]);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: span_text.pop_back();
          1: span_text.push_back(8'h61 + 8'($urandom_range(25)));
          default: span_text[$urandom_range(span_text.size() - 1)] =
                       8'h61 + 8'($urandom_range(25));
        endcase
      end
    end else if (pick < 55) begin
      span_text.push_back(HASH_CHAR);
      n = ($urandom_range(9) < 8) ? ($urandom_range(1) ? 3 : 6) : $urandom_range(8);
      for (int i = 0; i < n; i++) span_text.push_back(hex_chars[$urandom_range(21)]);
      if ($urandom_range(9) == 0) begin
        span_text[$urandom_range(n)] = 8'($urandom_range(255));
      end
    end else if (pick < 65) begin
      word = "none";
      for (int i = 0; i < word.len(); i++) span_text.push_back(word[i]);
    end else if (pick < 85) begin
      n = $urandom_range(17);
      for (int i = 0; i < n; i++) span_text.push_back(8'($urandom_range(255)));
      if (n > 0 && $urandom_range(3) == 0) span_text[0] = HASH_CHAR;
    end else begin
      n = $urandom_range(20, 15);
      word = paint_name[$urandom_range(NAME_COUNT - 1)];
      for (int i = 0; i < n; i++) begin
        span_text.push_back($urandom_range(1) ? word[i % word.len()]
                                              : hex_chars[$urandom_range(21)]);
      end
      if ($urandom_range(1)) span_text[0] = HASH_CHAR;
    end
    for (int i = 0; i < span_text.size(); i++) begin
      if (span_text[i] >= 8'h61 && span_text[i] <= 8'h7a && $urandom_range(1)) begin
        span_text[i] = span_text[i] - 8'h20;
      end
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    paint_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (colour_due.size() == 0) begin
        report($sformatf("unexpected result colour %06h no_paint %0b", m_axis_tdata,
                         m_axis_tuser));
      end else begin
        due = colour_due.pop_front();
        if (m_axis_tdata !== due.rgb) begin
          report($sformatf("colour %06h, expected %06h", m_axis_tdata, due.rgb));
        end
        if (m_axis_tuser !== due.np) begin
          report($sformatf("no_paint %0b, expected %0b", m_axis_tuser, due.np));
        end
      end
    end
  end

  initial begin
    paint_t want;
    int spans;
    paint_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (paint_cases[r]) begin
      span_text.delete();
      for (int i = 0; i < paint_cases[r].text.len(); i++) begin
        span_text.push_back(paint_cases[r].text[i]);
      end
      want.rgb = paint_cases[r].rgb;
      want.np = paint_cases[r].np;
      send_span(paint_cases[r].close_empty, paint_cases[r].gap_empty, paint_cases[r].typed,
                want);
    end

    spans = 0;
    want.rgb = 24'h0;
    want.np = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      steady = (spans >= 25 && spans < 45);
      if (spans == 10) squeeze_req = 1'b1;
      build_random_span();
      send_span($urandom_range(6) == 0, $urandom_range(9) == 0, 1'b0, want);
      spans++;
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (colour_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cpc_pkg.sv
sv/cpc_kw_match.sv
sv/css_paint_colour_parser_top.sv
bench/css_paint_colour_parser_top_tb.sv
